// File: rtl/core/gmig_pkg.sv
// Package for the grid mesh index generator: widths, register indexes,
// walk mode codes, configuration and queue word types. No dependencies.
`timescale 1ns / 1ps

package gmig_pkg;

  // Field widths
  localparam int IDX_W  = 32;
  localparam int DIM_W  = 13;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 3;

  // Default grid dimension limit
  localparam int MAX_GRID_DIM_DEF = 4096;

  // Position queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port
  localparam logic [ADDR_W-1:0] REG_WALK_MODE     = 3'd0;
  localparam logic [ADDR_W-1:0] REG_BASE_OFFSET   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_COL_COUNT     = 3'd2;
  localparam logic [ADDR_W-1:0] REG_ROW_COUNT     = 3'd3;
  localparam logic [ADDR_W-1:0] REG_COLUMN_MAJOR  = 3'd4;
  localparam logic [ADDR_W-1:0] REG_RESTART_VALUE = 3'd5;

  // Walk modes
  localparam logic [MODE_W-1:0] MODE_LINEAR     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATCH      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COL_STRIPS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROW_STRIPS = 2'd3;

  // Configuration register set
  typedef struct packed {
    logic [MODE_W-1:0] walk_mode;
    logic [IDX_W-1:0]  base_offset;
    logic [DIM_W-1:0]  col_count;
    logic [DIM_W-1:0]  row_count;
    logic              column_major;
    logic [IDX_W-1:0]  restart_value;
  } cfg_t;

  // One walk position, as queued for the back end.
  // index = base + mul_a * mul_b + addend; in patch mode mul_b is also the stride.
  typedef struct packed {
    logic             patch;
    logic             restart;
    logic             walk_last;
    logic [DIM_W-1:0] mul_a;
    logic [DIM_W-1:0] mul_b;
    logic [DIM_W-1:0] addend;
  } pos_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/gmig_front.sv
// Front end: accepts ticks, runs the walk counters and classifies each
// position into a queue word. Depends on gmig_pkg.
`timescale 1ns / 1ps

module gmig_front
  import gmig_pkg::*;
#(
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  logic    in_start_walk,
  input  q_stat_t q_stat,
  output logic    in_stall,
  output logic    push,
  output pos_t    push_word
);

  logic [DIM_W-1:0] outer_r, outer_nxt;
  logic [DIM_W-1:0] inner_r, inner_nxt;
  logic             finished_r, finished_nxt;

  logic [DIM_W-1:0] col_c, row_c, lim_l, lim_m, ol, il;
  logic [DIM_W:0]   inc_i, o_w, i_w;
  logic             advance, act, bad, last, direct;
  logic [DIM_W-1:0] o_n, i_n;

  assign in_stall = q_stat.full;
  assign advance  = in_valid && !in_stall;
  assign act      = advance && (in_start_walk || !finished_r);

  // Clamp oversized dimensions
  always_comb begin
    col_c = (32'(cfg.col_count) > 32'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : cfg.col_count;
    row_c = (32'(cfg.row_count) > 32'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : cfg.row_count;
    lim_l = cfg.column_major ? row_c : col_c;
    lim_m = cfg.column_major ? col_c : row_c;
  end

  // Outer and inner limits per mode
  always_comb begin
    unique case (cfg.walk_mode)
      MODE_LINEAR: begin
        ol = row_c;
        il = col_c;
      end
      MODE_PATCH: begin
        ol = (lim_m < DIM_W'(2)) ? '0 : lim_m - DIM_W'(1);
        il = (lim_l < DIM_W'(2)) ? '0 : lim_l - DIM_W'(1);
      end
      MODE_COL_STRIPS: begin
        ol = col_c;
        il = row_c;
      end
      default: begin
        ol = row_c;
        il = col_c;
      end
    endcase
  end

  // Next walk position
  always_comb begin
    inc_i = {1'b0, inner_r} + (DIM_W+1)'(1);
    if (in_start_walk) begin
      o_w = '0;
      i_w = '0;
    end else if (inc_i >= {1'b0, il}) begin
      o_w = {1'b0, outer_r} + (DIM_W+1)'(1);
      i_w = '0;
    end else begin
      o_w = {1'b0, outer_r};
      i_w = inc_i;
    end
    o_n  = o_w[DIM_W-1:0];
    i_n  = i_w[DIM_W-1:0];
    bad  = (ol == '0) || (il == '0) || (o_w >= {1'b0, ol}) || (i_w >= {1'b0, il});
    last = (o_n == ol - DIM_W'(1)) && (i_n == il - DIM_W'(1));
  end

  // Classify the position into a queue word
  always_comb begin
    direct = (cfg.walk_mode == MODE_COL_STRIPS) ? cfg.column_major : !cfg.column_major;
    push_word.patch     = (cfg.walk_mode == MODE_PATCH);
    push_word.walk_last = last;
    push_word.restart   = cfg.walk_mode[1] && (i_n == il - DIM_W'(1));
    push_word.mul_a     = o_n;
    push_word.mul_b     = il;
    push_word.addend    = i_n;
    if (cfg.walk_mode == MODE_PATCH) begin
      // stride is the full storage line length
      push_word.mul_b = il + DIM_W'(1);
    end else if (cfg.walk_mode[1] && !direct) begin
      // transposed strip: outer steps by one, inner by strip count
      push_word.mul_a  = i_n;
      push_word.mul_b  = ol;
      push_word.addend = o_n;
    end
  end

  assign push = act && !bad;

  always_comb begin
    outer_nxt    = outer_r;
    inner_nxt    = inner_r;
    finished_nxt = finished_r;
    if (act) begin
      outer_nxt    = o_n;
      inner_nxt    = i_n;
      finished_nxt = bad || last;
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r    <= '0;
      inner_r    <= '0;
      finished_r <= 1'b1;
    end else begin
      outer_r    <= outer_nxt;
      inner_r    <= inner_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

// File: rtl/core/gmig_queue.sv
// Short position queue between the front and back ends.
// Depends on gmig_pkg.
`timescale 1ns / 1ps

module gmig_queue
  import gmig_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  pos_t    push_word,
  input  logic    pop,
  output pos_t    head_word,
  output q_stat_t q_stat
);

  pos_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic               do_push, do_pop;

  assign q_stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_word    = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// File: rtl/core/gmig_back.sv
// Back end: multiplies out each queued position, adds the base offset and
// emits its indices one word per cycle through an output register while
// out_stall is low. Depends on gmig_pkg.
`timescale 1ns / 1ps

module gmig_back
  import gmig_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  q_stat_t          q_stat,
  input  pos_t             head_word,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_vertex_index,
  output logic             out_is_restart,
  output logic             out_last_of_tick,
  output logic             out_walk_done
);

  // Multiply stage
  logic               m_valid_r, m_valid_nxt;
  logic [2*DIM_W-1:0] m_prod_r;
  pos_t               m_pos_r;

  // Emit stage
  logic               e_valid_r, e_valid_nxt;
  logic [IDX_W-1:0]   e_idx_r;
  logic [DIM_W-1:0]   e_stride_r;
  logic               e_patch_r, e_restart_r, e_last_r;
  logic [1:0]         e_sub_r, e_sub_nxt;

  // Output register
  logic               o_valid_r, o_valid_nxt;
  logic [IDX_W-1:0]   o_index_r;
  logic               o_restart_r, o_last_tick_r, o_done_r;

  logic               out_load, e_final, e_done, e_free, m_adv, m_free;
  logic [DIM_W:0]     sub_off;
  logic [IDX_W-1:0]   sub_index;
  logic               sub_restart;

  // Handshake between stages
  always_comb begin
    if (e_patch_r) begin
      e_final = (e_sub_r == 2'd3);
    end else if (e_restart_r) begin
      e_final = (e_sub_r == 2'd1);
    end else begin
      e_final = 1'b1;
    end
    out_load = e_valid_r && (!o_valid_r || !out_stall);
    e_done   = out_load && e_final;
    e_free   = !e_valid_r || e_done;
    m_adv    = m_valid_r && e_free;
    m_free   = !m_valid_r || m_adv;
    pop      = m_free && !q_stat.empty;
  end

  // Index of the current sub-word
  always_comb begin
    unique case (e_sub_r)
      2'd0: sub_off = '0;
      2'd1: sub_off = {1'b0, e_stride_r};
      2'd2: sub_off = {1'b0, e_stride_r} + (DIM_W+1)'(1);
      default: sub_off = (DIM_W+1)'(1);
    endcase
    sub_restart = !e_patch_r && (e_sub_r != 2'd0);
    sub_index   = sub_restart ? cfg.restart_value : e_idx_r + IDX_W'(sub_off);
  end

  always_comb begin
    m_valid_nxt = pop ? 1'b1 : (m_adv ? 1'b0 : m_valid_r);
    e_valid_nxt = m_adv ? 1'b1 : (e_done ? 1'b0 : e_valid_r);
    o_valid_nxt = out_load ? 1'b1 : (out_stall ? o_valid_r : 1'b0);
    e_sub_nxt   = e_sub_r;
    if (m_adv) begin
      e_sub_nxt = '0;
    end else if (out_load) begin
      e_sub_nxt = e_sub_r + 2'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      e_sub_r   <= '0;
    end else begin
      m_valid_r <= m_valid_nxt;
      e_valid_r <= e_valid_nxt;
      o_valid_r <= o_valid_nxt;
      e_sub_r   <= e_sub_nxt;
    end
  end

  // Multiply stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod_r <= head_word.mul_a * head_word.mul_b;
      m_pos_r  <= head_word;
    end
  end

  // Emit stage payload: base + product + addend
  always_ff @(posedge clk) begin
    if (m_adv) begin
      e_idx_r     <= cfg.base_offset + IDX_W'(m_prod_r) + IDX_W'(m_pos_r.addend);
      e_stride_r  <= m_pos_r.mul_b;
      e_patch_r   <= m_pos_r.patch;
      e_restart_r <= m_pos_r.restart;
      e_last_r    <= m_pos_r.walk_last;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_index_r     <= sub_index;
      o_restart_r   <= sub_restart;
      o_last_tick_r <= e_final;
      o_done_r      <= e_final && e_last_r;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_vertex_index = o_index_r;
  assign out_is_restart   = o_restart_r;
  assign out_last_of_tick = o_last_tick_r;
  assign out_walk_done    = o_done_r;

endmodule

// File: rtl/core/grid_mesh_index_generator_top.sv
// Top level of the grid mesh index generator: configuration registers,
// front end, position queue and back end. Depends on gmig_pkg and gmig_*.
//
//   Port group  Direction  Handshake           Word
//   in_*        input      in_valid/in_stall   in_start_walk
//   out_*       output     out_valid/out_stall vertex_index, is_restart,
//                                              last_of_tick, walk_done
//   cfg_*       input      cfg_wr_en           cfg_addr, cfg_wdata
//
// A tick is accepted every cycle while the four-entry position queue has room.
// The back end emits one index per cycle while out_stall is low; a linear or
// inner strip position gives one index, a strip end two (index and restart),
// a patch position four. An accepted tick passes the queue, the multiply
// stage, the emit stage and the output register before out_valid rises.
// Reset is synchronous, active low.
// out_stall holds the output register; the queue absorbs ticks until it fills.
`timescale 1ns / 1ps

module grid_mesh_index_generator_top
  import gmig_pkg::*;
#(
  parameter int MAX_GRID_DIM = MAX_GRID_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [IDX_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_start_walk,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_vertex_index,
  output logic              out_is_restart,
  output logic              out_last_of_tick,
  output logic              out_walk_done
);

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  logic    push, pop;
  pos_t    push_word, head_word;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_WALK_MODE:     cfg_nxt.walk_mode     = cfg_wdata[MODE_W-1:0];
        REG_BASE_OFFSET:   cfg_nxt.base_offset   = cfg_wdata;
        REG_COL_COUNT:     cfg_nxt.col_count     = cfg_wdata[DIM_W-1:0];
        REG_ROW_COUNT:     cfg_nxt.row_count     = cfg_wdata[DIM_W-1:0];
        REG_COLUMN_MAJOR:  cfg_nxt.column_major  = cfg_wdata[0];
        REG_RESTART_VALUE: cfg_nxt.restart_value = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.walk_mode     <= MODE_LINEAR;
      cfg_r.base_offset   <= '0;
      cfg_r.col_count     <= DIM_W'(1);
      cfg_r.row_count     <= DIM_W'(1);
      cfg_r.column_major  <= 1'b0;
      cfg_r.restart_value <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gmig_front #(
    .MAX_GRID_DIM (MAX_GRID_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_start_walk (in_start_walk),
    .q_stat        (q_stat),
    .in_stall      (in_stall),
    .push          (push),
    .push_word     (push_word)
  );

  gmig_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_stat    (q_stat)
  );

  gmig_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .head_word        (head_word),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_vertex_index (out_vertex_index),
    .out_is_restart   (out_is_restart),
    .out_last_of_tick (out_last_of_tick),
    .out_walk_done    (out_walk_done)
  );

endmodule
